// ===== sv/totient_mobius_sieve_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the totient / Mobius sieve unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOTIENT_MOBIUS_SIEVE_UNIT_MACROS_SVH
`define TOTIENT_MOBIUS_SIEVE_UNIT_MACROS_SVH

// Same-cycle implication.
`define TMS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tms assertion failed");

// Next-cycle implication.
`define TMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tms assertion failed");

`endif

// ===== sv/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// Types and fixed constants of the totient / Mobius sieve unit.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int IDX_W = 17;
  localparam int TOT_W = 16;

  localparam logic [IDX_W-1:0] LIMIT_RESET = 17'h10000;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUILT = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  localparam logic [1:0] MU_ZERO = 2'b00;
  localparam logic [1:0] MU_POS  = 2'b01;
  localparam logic [1:0] MU_NEG  = 2'b11;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRESP,
    S_BINIT,
    S_BCLR,
    S_BRDI,
    S_BCHKI,
    S_BRDP,
    S_BMUL,
    S_BMARK,
    S_BNEXTI,
    S_BDONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic q_load;
    logic b_init;
    logic clr;
    logic rd_i;
    logic chk_i;
    logic mul;
    logic mark;
    logic next_i;
    logic b_done;
  } cmd_t;

  typedef struct packed {
    logic top_ge2;
    logic clr_last;
    logic i_last;
    logic j_lt_cnt;
    logic prod_gt_top;
    logic p_is_lp;
  } stat_t;

endpackage

// ===== sv/tms_in_if.sv =====
// ----------------------------------------------------------------------------
// tms_in_if
// Request channel: build or query items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tms_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [tms_pkg::IDX_W-1:0]  index;

  modport source (output valid, output opcode, output index, input ready);
  modport sink (input valid, input opcode, input index, output ready);
endinterface

// ===== sv/tms_out_if.sv =====
// ----------------------------------------------------------------------------
// tms_out_if
// Response channel: totient, Mobius value and status with valid/ready.
// ----------------------------------------------------------------------------
interface tms_out_if;
  logic                       valid;
  logic                       ready;
  logic [tms_pkg::TOT_W-1:0]  totient;
  logic signed [1:0]          mobius;
  logic [1:0]                 status;

  modport source (output valid, output totient, output mobius, output status,
                  input ready);
  modport sink (input valid, input totient, input mobius, input status,
                output ready);
endinterface

// ===== sv/tms_ctrl.sv =====
// ----------------------------------------------------------------------------
// tms_ctrl
// Sequencer for queries and sieve builds; owns the response valid flag.
// ----------------------------------------------------------------------------
`include "totient_mobius_sieve_unit_macros.svh"

module tms_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_opcode,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  tms_pkg::stat_t  stat,
  output tms_pkg::cmd_t   cmd
);

  tms_pkg::state_t state;
  tms_pkg::state_t state_next;
  logic            acc;

  assign req_ready = (state == tms_pkg::S_IDLE) && (!rsp_valid || rsp_ready);
  assign acc       = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tms_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.q_load || cmd.b_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tms_pkg::S_IDLE: begin
        if (acc) begin
          state_next = (req_opcode == tms_pkg::OP_QUERY) ? tms_pkg::S_QRESP
                                                         : tms_pkg::S_BINIT;
        end
      end
      tms_pkg::S_QRESP:  state_next = tms_pkg::S_IDLE;
      tms_pkg::S_BINIT:  state_next = stat.top_ge2 ? tms_pkg::S_BCLR : tms_pkg::S_BDONE;
      tms_pkg::S_BCLR:   state_next = stat.clr_last ? tms_pkg::S_BRDI : tms_pkg::S_BCLR;
      tms_pkg::S_BRDI:   state_next = tms_pkg::S_BCHKI;
      tms_pkg::S_BCHKI:  state_next = tms_pkg::S_BRDP;
      tms_pkg::S_BRDP:   state_next = stat.j_lt_cnt ? tms_pkg::S_BMUL : tms_pkg::S_BNEXTI;
      tms_pkg::S_BMUL:   state_next = tms_pkg::S_BMARK;
      tms_pkg::S_BMARK: begin
        if (stat.prod_gt_top || stat.p_is_lp) begin
          state_next = tms_pkg::S_BNEXTI;
        end else begin
          state_next = tms_pkg::S_BRDP;
        end
      end
      tms_pkg::S_BNEXTI: state_next = stat.i_last ? tms_pkg::S_BDONE : tms_pkg::S_BRDI;
      tms_pkg::S_BDONE:  state_next = tms_pkg::S_IDLE;
      default:           state_next = tms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      tms_pkg::S_IDLE:   cmd.accept = acc;
      tms_pkg::S_QRESP:  cmd.q_load = 1'b1;
      tms_pkg::S_BINIT:  cmd.b_init = 1'b1;
      tms_pkg::S_BCLR:   cmd.clr    = 1'b1;
      tms_pkg::S_BRDI:   cmd.rd_i   = 1'b1;
      tms_pkg::S_BCHKI:  cmd.chk_i  = 1'b1;
      tms_pkg::S_BRDP:   cmd        = '0;
      tms_pkg::S_BMUL:   cmd.mul    = 1'b1;
      tms_pkg::S_BMARK:  cmd.mark   = 1'b1;
      tms_pkg::S_BNEXTI: cmd.next_i = !stat.i_last;
      tms_pkg::S_BDONE:  cmd.b_done = 1'b1;
      default:           cmd        = '0;
    endcase
  end

  `TMS_ASSERT_IMPL(a_ready_only_idle, req_ready, (state == tms_pkg::S_IDLE))
  `TMS_ASSERT_IMPL(a_ready_has_room, req_ready, (!rsp_valid || rsp_ready))
  `TMS_ASSERT_NEXT(a_query_answers, (state == tms_pkg::S_QRESP), rsp_valid)
  `TMS_ASSERT_IMPL(a_done_slot_free, (state == tms_pkg::S_BDONE), !rsp_valid)

endmodule

// ===== sv/tms_datapath.sv =====
// ----------------------------------------------------------------------------
// tms_datapath
// Sieve tables, prime list, loop counters, multipliers and response register.
// ----------------------------------------------------------------------------
module tms_datapath #(
  parameter int MAX_N      = 65536,
  parameter int MAX_PRIMES = 6542
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [tms_pkg::IDX_W-1:0]  cfg_data,
  input  logic [tms_pkg::IDX_W-1:0]  req_index,
  input  tms_pkg::cmd_t              cmd,
  output tms_pkg::stat_t             stat,
  output logic [tms_pkg::TOT_W-1:0]  totient,
  output logic signed [1:0]          mobius,
  output logic [1:0]                 status
);

  localparam int NW = $clog2(MAX_N + 1);
  localparam int XW = (NW > tms_pkg::IDX_W) ? NW : tms_pkg::IDX_W;
  localparam int CW = $clog2(MAX_PRIMES + 1);
  localparam int PA = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int TW = tms_pkg::TOT_W;

  // Tables and prime list.
  logic          mark_mem [0:MAX_N];
  logic [TW-1:0] phi_mem  [0:MAX_N];
  logic [1:0]    mu_mem   [0:MAX_N];
  logic [NW-1:0] lp_mem   [0:MAX_N];
  logic [NW-1:0] plist    [0:MAX_PRIMES-1];

  logic          mark_rd;
  logic [TW-1:0] phi_rd;
  logic [1:0]    mu_rd;
  logic [NW-1:0] lp_rd;
  logic [NW-1:0] p_rd;

  logic [tms_pkg::IDX_W-1:0] limit;
  logic [NW-1:0]   built;
  logic [CW-1:0]   cnt;
  logic [NW-1:0]   top;
  logic [NW-1:0]   c;
  logic [NW-1:0]   i;
  logic [CW-1:0]   j;
  logic [NW-1:0]   p_q;
  logic [2*NW-1:0] prod;
  logic [TW-1:0]   phi_mp;
  logic [TW-1:0]   phi_mq;
  logic [TW-1:0]   phi_i;
  logic [1:0]      mu_i;
  logic [NW-1:0]   lp_i;
  logic            err_q;

  logic [XW-1:0]   lim_x;
  logic [XW-1:0]   k_x;
  logic [NW-1:0]   top_c;
  logic [NW-1:0]   idx_addr;
  logic [NW-1:0]   rd_addr;
  logic [NW-1:0]   m;
  logic            q_err;
  logic            is_prime;
  logic            list_room;
  logic            prod_gt;
  logic            hit_lp;

  logic          mark_we;
  logic [NW-1:0] mark_wa;
  logic          mark_wd;
  logic          tab_we;
  logic [NW-1:0] tab_wa;
  logic [TW-1:0] phi_wd;
  logic [1:0]    mu_wd;
  logic [NW-1:0] lp_wd;
  logic          pl_we;

  assign lim_x     = XW'(limit);
  assign k_x       = XW'(req_index);
  assign idx_addr  = k_x[NW-1:0];
  assign rd_addr   = cmd.rd_i ? i : idx_addr;
  assign m         = prod[NW-1:0];
  assign is_prime  = !mark_rd;
  assign list_room = (cnt < CW'(MAX_PRIMES));
  assign prod_gt   = (prod > (2*NW)'(top));
  // A prime divides i exactly when it equals the smallest factor of i,
  // because primes are tried in increasing order.
  assign hit_lp    = (p_q == lp_i);

  always_comb begin
    if (limit == '0) begin
      top_c = NW'(1);
    end else if (lim_x > XW'(MAX_N)) begin
      top_c = NW'(MAX_N);
    end else begin
      top_c = lim_x[NW-1:0];
    end
  end

  assign q_err = (built == '0) || (req_index == '0) || (k_x > XW'(built));

  assign stat.top_ge2     = (top_c >= NW'(2));
  assign stat.clr_last    = (c == top);
  assign stat.i_last      = (i == top);
  assign stat.j_lt_cnt    = (j < cnt);
  assign stat.prod_gt_top = prod_gt;
  assign stat.p_is_lp     = hit_lp;

  always_comb begin
    mark_we = 1'b0;
    mark_wa = c;
    mark_wd = 1'b0;
    if (cmd.clr) begin
      mark_we = 1'b1;
    end else if (cmd.mark && !prod_gt) begin
      mark_we = 1'b1;
      mark_wa = m;
      mark_wd = 1'b1;
    end
  end

  always_comb begin
    tab_we = 1'b0;
    tab_wa = m;
    phi_wd = hit_lp ? phi_mp : phi_mq;
    mu_wd  = hit_lp ? tms_pkg::MU_ZERO : 2'(-mu_i);
    lp_wd  = p_q;
    if (cmd.b_init) begin
      tab_we = 1'b1;
      tab_wa = NW'(1);
      phi_wd = TW'(1);
      mu_wd  = tms_pkg::MU_POS;
      lp_wd  = NW'(1);
    end else if (cmd.chk_i && is_prime) begin
      tab_we = 1'b1;
      tab_wa = i;
      phi_wd = TW'(i - NW'(1));
      mu_wd  = tms_pkg::MU_NEG;
      lp_wd  = i;
    end else if (cmd.mark && !prod_gt) begin
      tab_we = 1'b1;
    end
  end

  assign pl_we = cmd.chk_i && is_prime && list_room;

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_rd <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      phi_mem[tab_wa] <= phi_wd;
      mu_mem[tab_wa]  <= mu_wd;
      lp_mem[tab_wa]  <= lp_wd;
    end
    phi_rd <= phi_mem[rd_addr];
    mu_rd  <= mu_mem[rd_addr];
    lp_rd  <= lp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      plist[cnt[PA-1:0]] <= i;
    end
    p_rd <= plist[j[PA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= tms_pkg::LIMIT_RESET;
      built <= '0;
      cnt   <= '0;
    end else begin
      if (cfg_write) begin
        limit <= cfg_data;
      end
      if (cmd.b_init) begin
        cnt <= '0;
      end else if (pl_we) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.b_done) begin
        built <= top;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err_q <= q_err;
    end
    if (cmd.b_init) begin
      top <= top_c;
      c   <= NW'(2);
      i   <= NW'(2);
    end
    if (cmd.clr) begin
      c <= c + NW'(1);
    end
    if (cmd.chk_i) begin
      j <= '0;
      if (is_prime) begin
        phi_i <= TW'(i - NW'(1));
        mu_i  <= tms_pkg::MU_NEG;
        lp_i  <= i;
      end else begin
        phi_i <= phi_rd;
        mu_i  <= mu_rd;
        lp_i  <= lp_rd;
      end
    end
    if (cmd.mul) begin
      p_q    <= p_rd;
      prod   <= (2*NW)'(i) * (2*NW)'(p_rd);
      phi_mp <= TW'(phi_i * p_rd);
      phi_mq <= TW'(phi_i * (p_rd - NW'(1)));
    end
    if (cmd.mark) begin
      j <= j + CW'(1);
    end
    if (cmd.next_i) begin
      i <= i + NW'(1);
    end
    if (cmd.q_load) begin
      if (err_q) begin
        totient <= '0;
        mobius  <= '0;
        status  <= tms_pkg::ST_ERR;
      end else begin
        totient <= phi_rd;
        mobius  <= mu_rd;
        status  <= tms_pkg::ST_OK;
      end
    end else if (cmd.b_done) begin
      totient <= '0;
      mobius  <= '0;
      status  <= tms_pkg::ST_BUILT;
    end
  end

endmodule

// ===== sv/totient_mobius_sieve_unit.sv =====
// ----------------------------------------------------------------------------
// totient_mobius_sieve_unit
// Linear sieve engine answering Euler totient and Mobius queries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries an opcode and an index. A build item runs a linear sieve from
//   2 up to the limit register; a query item returns phi(index) and
//   mu(index) on rsp, with status 0, or status 2 for zero, an index above
//   the last build, or no build yet. A build answers with status 1.
//   Every item gives exactly one transfer on rsp.
// Timing:
//   For a query the table read is registered at the transfer edge and the
//   response register loads at the next one. A build walks each index from
//   2 up to top, the clamped limit, running inner sieve steps over the
//   prime list: one per composite plus one per index whose prime scan stops
//   on a product above top. One item is in flight at a time.
// Reset and stall:
//   Reset sets the limit to 65536 and marks the tables as not built.
//   Composite marks are cleared at the start of every build with top >= 2.
//   While rsp is stalled the response holds and no new request is taken.
// ----------------------------------------------------------------------------
module totient_mobius_sieve_unit #(
  parameter int MAX_N      = 65536,
  parameter int MAX_PRIMES = 6542
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [tms_pkg::IDX_W-1:0]  cfg_data,
  tms_in_if.sink                     req,
  tms_out_if.source                  rsp
);

  tms_pkg::cmd_t  cmd;
  tms_pkg::stat_t stat;

  tms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tms_datapath #(
    .MAX_N      (MAX_N),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req_index (req.index),
    .cmd       (cmd),
    .stat      (stat),
    .totient   (rsp.totient),
    .mobius    (rsp.mobius),
    .status    (rsp.status)
  );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for totient_mobius_sieve_unit
// Drives build and query items with random idling and stalls. It predicts
// each response with its own linear sieve and checks every field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TABLE_N = 65536;
  localparam int IW = tms_pkg::IDX_W;

  typedef struct packed {
    logic                      op;
    logic [tms_pkg::IDX_W-1:0] idx;
  } sieve_req_t;

  typedef struct packed {
    logic [tms_pkg::TOT_W-1:0] tot;
    logic [1:0]                mu;
    logic [1:0]                st;
  } sieve_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [tms_pkg::IDX_W-1:0] cfg_data = '0;

  tms_in_if  req ();
  tms_out_if rsp ();

  totient_mobius_sieve_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  int unsigned phi_tab [TABLE_N+1];
  int          mu_tab  [TABLE_N+1];
  bit          comp_tab[TABLE_N+1];
  int unsigned prime_tab[$];
  int unsigned pred_limit = 32'(tms_pkg::LIMIT_RESET);
  int unsigned pred_built = 0;

  sieve_req_t pending_q[$];
  sieve_rsp_t answer_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;

  task automatic sieve_build();
    int unsigned top;
    int unsigned p;
    int unsigned m;
    top = pred_limit;
    if (top < 1) top = 1;
    if (top > TABLE_N) top = TABLE_N;
    foreach (comp_tab[k]) comp_tab[k] = 1'b0;
    prime_tab.delete();
    phi_tab[1] = 1;
    mu_tab[1] = 1;
    for (int unsigned i = 2; i <= top; i++) begin
      if (!comp_tab[i]) begin
        prime_tab.insert(prime_tab.size(), i);
        phi_tab[i] = i - 1;
        mu_tab[i] = -1;
      end
      for (int j = 0; j < prime_tab.size(); j++) begin
        p = prime_tab[j];
        if (longint'(i) * p > top) break;
        m = i * p;
        comp_tab[m] = 1'b1;
        if (i % p == 0) begin
          phi_tab[m] = phi_tab[i] * p;
          mu_tab[m] = 0;
          break;
        end
        phi_tab[m] = phi_tab[i] * (p - 1);
        mu_tab[m] = -mu_tab[i];
      end
    end
    pred_built = top;
  endtask

  task automatic predict_answer(input sieve_req_t r);
    sieve_rsp_t a;
    a = '0;
    if (r.op == tms_pkg::OP_BUILD) begin
      sieve_build();
      a.st = tms_pkg::ST_BUILT;
    end else if (pred_built == 0 || r.idx == 0 || r.idx > pred_built) begin
      a.st = tms_pkg::ST_ERR;
    end else begin
      a.tot = phi_tab[r.idx][tms_pkg::TOT_W-1:0];
      a.mu = (mu_tab[r.idx] == 0) ? tms_pkg::MU_ZERO :
             (mu_tab[r.idx] > 0) ? tms_pkg::MU_POS : tms_pkg::MU_NEG;
      a.st = tms_pkg::ST_OK;
    end
    answer_q.insert(answer_q.size(), a);
  endtask

  // Driver: a new item is offered only when the slot is free or transfers.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.opcode <= tms_pkg::OP_BUILD;
      req.index <= '0;
    end else begin
      if (req.valid && req.ready) predict_answer('{req.opcode, req.index});
      if (!req.valid || req.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          sieve_req_t r;
          r = pending_q.pop_front();
          req.valid <= 1'b1;
          req.opcode <= r.op;
          req.index <= r.idx;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once it is requested.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_used <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_go && !hold_used) begin
      hold_cycles <= 400;
      hold_used <= 1'b1;
    end
  end

  // Monitor: random stalls plus the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected response tot=%0d mu=%0d st=%0d", $time,
                   rsp.totient, rsp.mobius, rsp.status);
          errors++;
        end else begin
          sieve_rsp_t e;
          e = answer_q.pop_front();
          if (rsp.totient !== e.tot) begin
            $display("%0t: totient expected %0d actual %0d", $time, e.tot, rsp.totient);
            errors++;
          end
          if (rsp.mobius !== e.mu) begin
            $display("%0t: mobius expected %0d actual %0d", $time,
                     $signed(e.mu), rsp.mobius);
            errors++;
          end
          if (rsp.status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, rsp.status);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  task automatic write_limit(input logic [tms_pkg::IDX_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    pred_limit = 32'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_item(input logic op, input logic [tms_pkg::IDX_W-1:0] idx);
    sieve_req_t r;
    r.op = op;
    r.idx = idx;
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || req.valid || answer_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int unsigned lim;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: queries before any build, then the full saturated build.
    add_item(tms_pkg::OP_QUERY, 17'd5);
    add_item(tms_pkg::OP_QUERY, 17'd0);
    drain();
    write_limit(17'h1FFFF);
    add_item(tms_pkg::OP_BUILD, 17'h1FFFF);
    add_item(tms_pkg::OP_QUERY, 17'd1);
    add_item(tms_pkg::OP_QUERY, 17'd2);
    add_item(tms_pkg::OP_QUERY, 17'd30);
    add_item(tms_pkg::OP_QUERY, 17'd65521);
    add_item(tms_pkg::OP_QUERY, 17'd65535);
    add_item(tms_pkg::OP_QUERY, 17'd65536);
    add_item(tms_pkg::OP_QUERY, 17'd65537);
    add_item(tms_pkg::OP_QUERY, 17'h1FFFF);
    add_item(tms_pkg::OP_QUERY, 17'd0);
    drain();
    // Limit of zero still covers index one.
    write_limit(17'd0);
    add_item(tms_pkg::OP_BUILD, 17'd0);
    add_item(tms_pkg::OP_QUERY, 17'd1);
    add_item(tms_pkg::OP_QUERY, 17'd2);
    drain();
    write_limit(17'd2);
    add_item(tms_pkg::OP_BUILD, 17'h10000);
    add_item(tms_pkg::OP_QUERY, 17'd2);
    add_item(tms_pkg::OP_QUERY, 17'd3);
    drain();

    for (int seg = 0; seg < 16; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      lim = ($urandom_range(7, 0) == 0) ? $urandom_range(3, 0) : $urandom_range(600, 1);
      write_limit(lim[tms_pkg::IDX_W-1:0]);
      // Sometimes queries still see the previous build for a while.
      if ($urandom_range(3, 0) != 0) begin
        add_item(tms_pkg::OP_BUILD, IW'($urandom_range(17'h1FFFF, 0)));
      end
      if (seg == 0) hold_go = 1'b1;
      for (int n = 0; n < 125; n++) begin
        case ($urandom_range(19, 0))
          0: add_item(tms_pkg::OP_BUILD, IW'($urandom_range(17'h1FFFF, 0)));
          1, 2: add_item(tms_pkg::OP_QUERY, IW'($urandom_range(17'h1FFFF, 0)));
          3: add_item(tms_pkg::OP_QUERY, 17'd0);
          default: add_item(tms_pkg::OP_QUERY, IW'($urandom_range(lim + 3, 0)));
        endcase
      end
      drain();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tms_pkg.sv
sv/tms_in_if.sv
sv/tms_out_if.sv
sv/tms_ctrl.sv
sv/tms_datapath.sv
sv/totient_mobius_sieve_unit.sv
bench/testbench.sv
